// File: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a implies c on every clock edge out of reset.
`define RMQ_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Check that c holds on every clock edge out of reset.
`define RMQ_ASSERT_ALWAYS(label, clk, rst_n, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (c)) \
    else $error("assertion failed");

`endif

// File: rtl/core/rmq_pkg.sv
// Types and constants of the rotation matrix to quaternion block.
package rmq_pkg;

  // Branch codes: which component takes the square-root part.
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;
  localparam logic [1:0] SEL_W = 2'd3;

  localparam int NUM_W  = 33;  // magnitude of a sum of two elements
  localparam int QUOT_W = 32;  // quotient bits produced before saturation

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r01;
    logic signed [31:0] r02;
    logic signed [31:0] r10;
    logic signed [31:0] r11;
    logic signed [31:0] r12;
    logic signed [31:0] r20;
    logic signed [31:0] r21;
    logic signed [31:0] r22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
  } rmq_out_t;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] mag;
  } rmq_num_t;

  typedef struct packed {
    logic [1:0] sel;
    rmq_num_t   n0;
    rmq_num_t   n1;
    rmq_num_t   n2;
  } rmq_side_t;

endpackage

// File: rtl/core/rmq_select.sv
// Branch selection, off-diagonal sums and radicand of the first stage.
module rmq_select #(
  parameter int FRACTION_BITS = 30,
  parameter int UW            = 35
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_in,
  input  rmq_pkg::rmq_in_t   d_in,
  output logic               vld_out,
  output logic [UW-2:0]      u_out,
  output rmq_pkg::rmq_side_t side_out
);

  logic signed [UW-1:0] e00, e11, e22, one_fx, trace, u_s;
  logic                 c0, c1;
  logic [1:0]           sel;
  logic signed [rmq_pkg::NUM_W-1:0] n0, n1, n2;
  logic               vld_r;
  logic [UW-2:0]      u_r, u_nxt;
  rmq_pkg::rmq_side_t side_r, side_nxt;

  function automatic rmq_pkg::rmq_num_t to_mag(input logic signed [rmq_pkg::NUM_W-1:0] n);
    rmq_pkg::rmq_num_t v;
    v.neg = n[rmq_pkg::NUM_W-1];
    v.mag = v.neg ? rmq_pkg::NUM_W'(-n) : rmq_pkg::NUM_W'(n);
    return v;
  endfunction

  function automatic logic signed [rmq_pkg::NUM_W-1:0] add2(input logic signed [31:0] a,
                                                            input logic signed [31:0] b);
    return rmq_pkg::NUM_W'(a) + rmq_pkg::NUM_W'(b);
  endfunction

  function automatic logic signed [rmq_pkg::NUM_W-1:0] sub2(input logic signed [31:0] a,
                                                            input logic signed [31:0] b);
    return rmq_pkg::NUM_W'(a) - rmq_pkg::NUM_W'(b);
  endfunction

  always_comb begin
    e00    = UW'(d_in.r00);
    e11    = UW'(d_in.r11);
    e22    = UW'(d_in.r22);
    one_fx = UW'(1) <<< FRACTION_BITS;
    trace  = e00 + e11 + e22;
    c0     = (d_in.r00 > d_in.r11) && (d_in.r00 > d_in.r22);
    c1     = d_in.r11 > d_in.r22;
    if (trace > 0) begin
      sel = rmq_pkg::SEL_W;
      u_s = one_fx + trace;
      n0  = sub2(d_in.r21, d_in.r12);
      n1  = sub2(d_in.r02, d_in.r20);
      n2  = sub2(d_in.r10, d_in.r01);
    end else if (c0) begin
      sel = rmq_pkg::SEL_X;
      u_s = one_fx + e00 - e11 - e22;
      n0  = add2(d_in.r01, d_in.r10);
      n1  = add2(d_in.r02, d_in.r20);
      n2  = sub2(d_in.r21, d_in.r12);
    end else if (c1) begin
      sel = rmq_pkg::SEL_Y;
      u_s = one_fx + e11 - e00 - e22;
      n0  = add2(d_in.r01, d_in.r10);
      n1  = add2(d_in.r12, d_in.r21);
      n2  = sub2(d_in.r02, d_in.r20);
    end else begin
      sel = rmq_pkg::SEL_Z;
      u_s = one_fx + e22 - e00 - e11;
      n0  = add2(d_in.r02, d_in.r20);
      n1  = add2(d_in.r12, d_in.r21);
      n2  = sub2(d_in.r10, d_in.r01);
    end
    // clamp a negative radicand to zero
    u_nxt        = u_s[UW-1] ? '0 : u_s[UW-2:0];
    side_nxt.sel = sel;
    side_nxt.n0  = to_mag(n0);
    side_nxt.n1  = to_mag(n1);
    side_nxt.n2  = to_mag(n2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    u_r    <= u_nxt;
    side_r <= side_nxt;
  end

  assign vld_out  = vld_r;
  assign u_out    = u_r;
  assign side_out = side_r;

endmodule

// File: rtl/core/rmq_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
module rmq_sqrt #(
  parameter int XW = 64,
  parameter int RW = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_in,
  input  logic [XW-1:0]      x_in,
  input  rmq_pkg::rmq_side_t side_in,
  output logic               vld_out,
  output logic [RW-1:0]      root_out,
  output rmq_pkg::rmq_side_t side_out
);

  logic [RW+1:0]      rem_r  [RW];
  logic [RW-1:0]      root_r [RW];
  logic [2*RW-1:0]    xs_r   [RW];
  rmq_pkg::rmq_side_t side_r [RW];
  logic               vld_r  [RW];

  logic [RW+1:0]      rem_i  [RW];
  logic [RW-1:0]      root_i [RW];
  logic [2*RW-1:0]    xs_i   [RW];
  rmq_pkg::rmq_side_t side_i [RW];
  logic               vld_i  [RW];

  logic [RW+1:0]      rem_nxt  [RW];
  logic [RW-1:0]      root_nxt [RW];
  logic [2*RW-1:0]    xs_nxt   [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW+1:0] rem_sh, trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_i[i]  = '0;
      assign root_i[i] = '0;
      assign xs_i[i]   = (2*RW)'(x_in);
      assign side_i[i] = side_in;
      assign vld_i[i]  = vld_in;
    end else begin : g_next
      assign rem_i[i]  = rem_r[i-1];
      assign root_i[i] = root_r[i-1];
      assign xs_i[i]   = xs_r[i-1];
      assign side_i[i] = side_r[i-1];
      assign vld_i[i]  = vld_r[i-1];
    end

    always_comb begin
      rem_sh      = {rem_i[i][RW-1:0], xs_i[i][2*RW-1 -: 2]};
      trial       = {root_i[i], 2'b01};
      ge          = rem_sh >= trial;
      rem_nxt[i]  = ge ? rem_sh - trial : rem_sh;
      root_nxt[i] = {root_i[i][RW-2:0], ge};
      xs_nxt[i]   = xs_i[i] << 2;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_i[i];
      end
      rem_r[i]  <= rem_nxt[i];
      root_r[i] <= root_nxt[i];
      xs_r[i]   <= xs_nxt[i];
      side_r[i] <= side_i[i];
    end
  end

  assign vld_out  = vld_r[RW-1];
  assign root_out = root_r[RW-1];
  assign side_out = side_r[RW-1];

endmodule

// File: rtl/core/rmq_div.sv
// Three-lane pipelined divider by twice the root, with saturation and placement.
module rmq_div #(
  parameter int FRACTION_BITS = 30,
  parameter int RW            = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_in,
  input  logic [RW-1:0]      root_in,
  input  rmq_pkg::rmq_side_t side_in,
  output logic               vld_out,
  output rmq_pkg::rmq_out_t  q_out
);

  localparam int QW = rmq_pkg::QUOT_W;
  localparam int DW = rmq_pkg::NUM_W + FRACTION_BITS;
  localparam int HW = DW - QW;
  localparam int CW = (HW > RW + 1) ? HW : RW + 1;

  typedef struct packed {
    logic          neg;
    logic          zero;
    logic          ovf;
    logic [RW:0]   rem;
    logic [QW-1:0] q;
    logic [QW-1:0] lo;
  } lane_t;

  typedef struct packed {
    logic        vld;
    logic [1:0]  sel;
    logic [31:0] big;
    logic [RW:0] den;
  } ctl_t;

  // pre stage: overflow check and remainder seed
  ctl_t  ctl0_r, ctl0_nxt;
  lane_t ln0_r [3];
  lane_t ln0_nxt [3];
  rmq_pkg::rmq_num_t nums [3];

  assign nums[0] = side_in.n0;
  assign nums[1] = side_in.n1;
  assign nums[2] = side_in.n2;

  always_comb begin
    logic [RW-1:0] half;
    logic [DW-1:0] dvd;
    logic [CW-1:0] hi_c, den_c;
    half          = root_in >> 1;
    ctl0_nxt.vld  = vld_in;
    ctl0_nxt.sel  = side_in.sel;
    ctl0_nxt.den  = {root_in, 1'b0};
    if (RW > 31 && (half >> 31) != '0) begin
      ctl0_nxt.big = 32'h7FFF_FFFF;
    end else begin
      ctl0_nxt.big = 32'(half);
    end
    den_c = CW'(ctl0_nxt.den);
    for (int k = 0; k < 3; k++) begin
      dvd              = DW'(nums[k].mag) << FRACTION_BITS;
      hi_c             = CW'(dvd[DW-1:QW]);
      ln0_nxt[k].neg   = nums[k].neg;
      ln0_nxt[k].zero  = nums[k].mag == '0;
      ln0_nxt[k].ovf   = hi_c >= den_c;
      ln0_nxt[k].rem   = hi_c[RW:0];
      ln0_nxt[k].q     = '0;
      ln0_nxt[k].lo    = dvd[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.vld <= 1'b0;
    end else begin
      ctl0_r.vld <= ctl0_nxt.vld;
    end
    ctl0_r.sel <= ctl0_nxt.sel;
    ctl0_r.big <= ctl0_nxt.big;
    ctl0_r.den <= ctl0_nxt.den;
    for (int k = 0; k < 3; k++) begin
      ln0_r[k] <= ln0_nxt[k];
    end
  end

  // one quotient bit per stage
  ctl_t  ctl_r  [QW];
  lane_t ln_r   [QW][3];
  ctl_t  ctl_i  [QW];
  lane_t ln_i   [QW][3];
  lane_t ln_nxt [QW][3];

  for (genvar j = 0; j < QW; j++) begin : g_step
    if (j == 0) begin : g_first
      assign ctl_i[j] = ctl0_r;
      for (genvar k = 0; k < 3; k++) begin : g_ln
        assign ln_i[j][k] = ln0_r[k];
      end
    end else begin : g_next
      assign ctl_i[j] = ctl_r[j-1];
      for (genvar k = 0; k < 3; k++) begin : g_ln
        assign ln_i[j][k] = ln_r[j-1][k];
      end
    end

    always_comb begin
      logic [RW+1:0] rem_sh;
      logic          ge;
      for (int k = 0; k < 3; k++) begin
        rem_sh           = {ln_i[j][k].rem, ln_i[j][k].lo[QW-1]};
        ge               = rem_sh >= {1'b0, ctl_i[j].den};
        ln_nxt[j][k]     = ln_i[j][k];
        ln_nxt[j][k].rem = ge ? (RW+1)'(rem_sh - {1'b0, ctl_i[j].den})
                              : rem_sh[RW:0];
        ln_nxt[j][k].q   = {ln_i[j][k].q[QW-2:0], ge};
        ln_nxt[j][k].lo  = ln_i[j][k].lo << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j].vld <= 1'b0;
      end else begin
        ctl_r[j].vld <= ctl_i[j].vld;
      end
      ctl_r[j].sel <= ctl_i[j].sel;
      ctl_r[j].big <= ctl_i[j].big;
      ctl_r[j].den <= ctl_i[j].den;
      for (int k = 0; k < 3; k++) begin
        ln_r[j][k] <= ln_nxt[j][k];
      end
    end
  end

  // output stage: saturate, apply sign, place the big part
  logic              vld_r;
  rmq_pkg::rmq_out_t q_r, q_nxt;

  always_comb begin
    logic [31:0] res [3];
    lane_t       l;
    ctl_t        c;
    c = ctl_r[QW-1];
    for (int k = 0; k < 3; k++) begin
      l = ln_r[QW-1][k];
      if (l.zero) begin
        res[k] = '0;
      end else if (l.ovf || l.q[QW-1]) begin
        res[k] = l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        res[k] = l.neg ? 32'(-l.q) : 32'(l.q);
      end
    end
    case (c.sel)
      rmq_pkg::SEL_X: q_nxt = {c.big, res[0], res[1], res[2]};
      rmq_pkg::SEL_Y: q_nxt = {res[0], c.big, res[1], res[2]};
      rmq_pkg::SEL_Z: q_nxt = {res[0], res[1], c.big, res[2]};
      default:        q_nxt = {res[0], res[1], res[2], c.big};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl_r[QW-1].vld;
    end
    q_r <= q_nxt;
  end

  assign vld_out = vld_r;
  assign q_out   = q_r;

endmodule

// File: rtl/core/rotation_matrix_to_quaternion.sv
// Throughput: one matrix per cycle; busy stays low as every stage advances each cycle.
// Depth: the select stage, the square root (one root bit per stage), then the divider.
// Reset (synchronous, active low) clears the valid bits only; no results follow it.
// The receiver cannot stall: each word is shown on out_data for one cycle.
`include "assert_macros.svh"

module rotation_matrix_to_quaternion #(
  parameter int FRACTION_BITS = 30
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rmq_pkg::rmq_in_t  in_data,
  output logic              out_valid,
  output rmq_pkg::rmq_out_t out_data
);

  localparam int UW     = ((FRACTION_BITS > 33) ? FRACTION_BITS : 33) + 2;
  localparam int XW     = UW - 1 + FRACTION_BITS;
  localparam int ROOT_W = (XW + 1) / 2;
  localparam int LAT    = ROOT_W + 35;

  logic               sel_vld, sq_vld;
  logic [UW-2:0]      u;
  logic [ROOT_W-1:0]  root;
  rmq_pkg::rmq_side_t sel_side, sq_side;

  assign busy = 1'b0;

  rmq_select #(
    .FRACTION_BITS(FRACTION_BITS),
    .UW           (UW)
  ) u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (start && !busy),
    .d_in    (in_data),
    .vld_out (sel_vld),
    .u_out   (u),
    .side_out(sel_side)
  );

  rmq_sqrt #(
    .XW(XW),
    .RW(ROOT_W)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (sel_vld),
    .x_in    (XW'(u) << FRACTION_BITS),
    .side_in (sel_side),
    .vld_out (sq_vld),
    .root_out(root),
    .side_out(sq_side)
  );

  rmq_div #(
    .FRACTION_BITS(FRACTION_BITS),
    .RW           (ROOT_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (sq_vld),
    .root_in(root),
    .side_in(sq_side),
    .vld_out(out_valid),
    .q_out  (out_data)
  );

  // a word out must stem from a start taken the pipeline depth earlier
  `RMQ_ASSERT_IMP(a_out_from_start, clk, rst_n, out_valid, $past(start, LAT))
  `RMQ_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
  // at least one component is non-negative, since the square-root part never is
  `RMQ_ASSERT_IMP(a_one_nonneg, clk, rst_n, out_valid,
                  !out_data.quat_x[31] || !out_data.quat_y[31] ||
                  !out_data.quat_z[31] || !out_data.quat_w[31])

endmodule

// File: sim/rotation_matrix_to_quaternion_tb.sv
// Self-checking testbench for the rotation matrix to quaternion pipeline.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;

  localparam int          FRAC       = 30;
  localparam longint      ONE        = 64'sd1 << FRAC;
  localparam int          CYCLE_MAX  = 400000;
  localparam int          DRAIN      = 100;
  localparam int          N_RANDOM   = 1700;
  localparam logic [31:0] Q_POS      = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_NEG      = 32'h8000_0000;
  localparam logic [31:0] P_ONE      = 32'h4000_0000;
  localparam logic [31:0] M_ONE      = 32'hC000_0000;

  typedef struct {
    rmq_pkg::rmq_in_t  m;
    bit                typed;
    rmq_pkg::rmq_out_t q;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  rmq_pkg::rmq_in_t  in_data;
  logic              out_valid;
  rmq_pkg::rmq_out_t out_data;

  rmq_pkg::rmq_out_t quat_due[$];
  int                fails = 0;
  int                cycles = 0;
  int                send_idle_pct = 0;

  rotation_matrix_to_quaternion #(.FRACTION_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // floor(sqrt(u * 2^FRAC))
  function automatic logic [63:0] fx_root(longint u);
    logic [127:0] target;
    logic [127:0] c;
    logic [63:0]  r;
    r = 0;
    target = 128'(u) << FRAC;
    for (int b = 40; b >= 0; b--) begin
      c = 128'(r | (64'd1 << b));
      if (c * c <= target) r = c[63:0];
    end
    return r;
  endfunction

  // num * 2^FRAC / den, truncated toward zero, saturated
  function automatic logic [31:0] fx_quot(longint num, logic [63:0] den);
    logic         neg;
    logic [127:0] mag;
    logic [127:0] q;
    neg = num < 0;
    mag = 128'(neg ? -num : num);
    if (mag == 0) return 32'd0;
    if (den == 0) return neg ? Q_NEG : Q_POS;
    q = (mag << FRAC) / 128'(den);
    if (!neg && q >= 128'h8000_0000) return Q_POS;
    if (neg && q > 128'h8000_0000) return Q_NEG;
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic rmq_pkg::rmq_out_t matrix_to_quat(rmq_pkg::rmq_in_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint tr, u, n0, n1, n2;
    logic [1:0]  sel;
    logic [63:0] root, den;
    logic [31:0] big, c0, c1, c2;
    rmq_pkg::rmq_out_t q;
    a00 = m.r00; a01 = m.r01; a02 = m.r02;
    a10 = m.r10; a11 = m.r11; a12 = m.r12;
    a20 = m.r20; a21 = m.r21; a22 = m.r22;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      sel = rmq_pkg::SEL_W; u = ONE + tr;
      n0 = a21 - a12; n1 = a02 - a20; n2 = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      sel = rmq_pkg::SEL_X; u = ONE + a00 - a11 - a22;
      n0 = a01 + a10; n1 = a02 + a20; n2 = a21 - a12;
    end else if (a11 > a22) begin
      sel = rmq_pkg::SEL_Y; u = ONE + a11 - a00 - a22;
      n0 = a01 + a10; n1 = a12 + a21; n2 = a02 - a20;
    end else begin
      sel = rmq_pkg::SEL_Z; u = ONE + a22 - a00 - a11;
      n0 = a02 + a20; n1 = a12 + a21; n2 = a10 - a01;
    end
    if (u < 0) u = 0;
    root = fx_root(u);
    den  = root << 1;
    big  = ((root >> 1) > 64'h7FFF_FFFF) ? Q_POS : root[32:1];
    c0 = fx_quot(n0, den);
    c1 = fx_quot(n1, den);
    c2 = fx_quot(n2, den);
    case (sel)
      rmq_pkg::SEL_X: begin
        q.quat_x = big; q.quat_y = c0; q.quat_z = c1; q.quat_w = c2;
      end
      rmq_pkg::SEL_Y: begin
        q.quat_x = c0; q.quat_y = big; q.quat_z = c1; q.quat_w = c2;
      end
      rmq_pkg::SEL_Z: begin
        q.quat_x = c0; q.quat_y = c1; q.quat_z = big; q.quat_w = c2;
      end
      default: begin
        q.quat_x = c0; q.quat_y = c1; q.quat_z = c2; q.quat_w = big;
      end
    endcase
    return q;
  endfunction

  function automatic logic [31:0] to_fx(real v);
    return 32'($rtoi(v * 1073741824.0));
  endfunction

  function automatic real rnd_unit();
    return $itor($urandom_range(0, 2000000)) / 1000000.0 - 1.0;
  endfunction

  // Proper rotation built from a random quaternion, optionally with small noise
  function automatic rmq_pkg::rmq_in_t rnd_rotation(bit noisy);
    real x, y, z, w, nrm;
    rmq_pkg::rmq_in_t m;
    x = rnd_unit(); y = rnd_unit(); z = rnd_unit(); w = rnd_unit();
    nrm = $sqrt(x*x + y*y + z*z + w*w);
    if (nrm < 1.0e-3) begin
      x = 0.0; y = 0.0; z = 0.0; w = 1.0; nrm = 1.0;
    end
    x = x / nrm; y = y / nrm; z = z / nrm; w = w / nrm;
    m.r00 = to_fx(1.0 - 2.0*(y*y + z*z));
    m.r01 = to_fx(2.0*(x*y - z*w));
    m.r02 = to_fx(2.0*(x*z + y*w));
    m.r10 = to_fx(2.0*(x*y + z*w));
    m.r11 = to_fx(1.0 - 2.0*(x*x + z*z));
    m.r12 = to_fx(2.0*(y*z - x*w));
    m.r20 = to_fx(2.0*(x*z - y*w));
    m.r21 = to_fx(2.0*(y*z + x*w));
    m.r22 = to_fx(1.0 - 2.0*(x*x + y*y));
    if (noisy) begin
      m = m ^ rmq_pkg::rmq_in_t'({9{$urandom_range(0, 32'hFFFF) & 32'h0000FFFF}});
    end
    return m;
  endfunction

  function automatic rmq_pkg::rmq_in_t rnd_raw();
    rmq_pkg::rmq_in_t m;
    m = {$urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom};
    return m;
  endfunction

  function automatic rmq_pkg::rmq_in_t diag(logic [31:0] a, logic [31:0] b,
                                            logic [31:0] c);
    rmq_pkg::rmq_in_t m;
    m = '0;
    m.r00 = a; m.r11 = b; m.r22 = c;
    return m;
  endfunction

  task automatic send_word(rmq_pkg::rmq_in_t m, bit typed, rmq_pkg::rmq_out_t q);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk) start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    quat_due = {quat_due, (typed ? q : matrix_to_quat(m))};
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("rotation_matrix_to_quaternion_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    rmq_pkg::rmq_out_t want;
    if (rst_n && out_valid) begin
      if (quat_due.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        fails++;
      end else begin
        want = quat_due.pop_front();
        if (out_data.quat_x !== want.quat_x) begin
          $error("quat_x expected %h actual %h", want.quat_x, out_data.quat_x); fails++;
        end
        if (out_data.quat_y !== want.quat_y) begin
          $error("quat_y expected %h actual %h", want.quat_y, out_data.quat_y); fails++;
        end
        if (out_data.quat_z !== want.quat_z) begin
          $error("quat_z expected %h actual %h", want.quat_z, out_data.quat_z); fails++;
        end
        if (out_data.quat_w !== want.quat_w) begin
          $error("quat_w expected %h actual %h", want.quat_w, out_data.quat_w); fails++;
        end
      end
    end
  end

  initial begin
    row_t             rows[$];
    row_t             r;
    rmq_pkg::rmq_in_t m;
    int               pick;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;

    // identity: trace branch, w takes one half of two
    r.m = diag(P_ONE, P_ONE, P_ONE); r.typed = 1;
    r.q = '{quat_x: 0, quat_y: 0, quat_z: 0, quat_w: 32'h4000_0000}; rows = {rows, r};
    // all zero: every tie falls through to the z branch
    r.m = '0; r.typed = 1;
    r.q = '{quat_x: 0, quat_y: 0, quat_z: 32'h2000_0000, quat_w: 0}; rows = {rows, r};
    r.typed = 0; r.q = '0;
    r.m = diag(P_ONE, M_ONE, M_ONE); rows = {rows, r};   // half turn about x
    r.m = diag(M_ONE, P_ONE, M_ONE); rows = {rows, r};   // half turn about y
    r.m = diag(M_ONE, M_ONE, P_ONE); rows = {rows, r};   // half turn about z
    r.m = diag(M_ONE, M_ONE, M_ONE); rows = {rows, r};   // ties, all negative
    r.m = diag(0, 0, M_ONE); rows = {rows, r};           // tie between r00 and r11
    r.m = diag(M_ONE, 0, 0); rows = {rows, r};           // tie between r11 and r22
    r.m = {9{Q_POS}}; rows = {rows, r};
    r.m = {9{Q_NEG}}; rows = {rows, r};
    r.m = {Q_NEG, Q_POS, Q_NEG, Q_POS, Q_NEG, Q_POS, Q_NEG, Q_POS, Q_NEG}; rows = {rows, r};
    r.m = {Q_POS, Q_NEG, Q_POS, Q_NEG, Q_POS, Q_NEG, Q_POS, Q_NEG, Q_POS}; rows = {rows, r};
    // large off-diagonal sums, one of which drives a quotient to saturation
    m = diag(M_ONE, M_ONE, P_ONE); m.r02 = Q_POS; m.r20 = Q_POS; m.r12 = Q_NEG; m.r21 = Q_NEG;
    r.m = m; rows = {rows, r};
    m = diag(32'd1, 32'd0, 32'hFFFF_FFFF); m.r01 = Q_NEG; m.r10 = Q_NEG; m.r21 = Q_POS;
    r.m = m; rows = {rows, r};
    m = diag(32'h8000_0001, 32'h8000_0001, 32'h8000_0001); m.r10 = Q_POS; m.r01 = Q_NEG;
    r.m = m; rows = {rows, r};
    r.m = diag(32'd1, 32'd0, 32'd0); rows = {rows, r};   // smallest positive trace
    r.m = diag(32'd0, 32'd1, 32'hFFFF_FFFF); rows = {rows, r};

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_word(rows[i].m, rows[i].typed, rows[i].q);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) send_idle_pct = 60;
      else if (i == 2 * N_RANDOM / 3) send_idle_pct = 0;
      else if (i == 0) send_idle_pct = 35;
      pick = $urandom_range(0, 99);
      if (pick < 60) m = rnd_rotation(0);
      else if (pick < 75) m = rnd_rotation(1);
      else m = rnd_raw();
      send_word(m, 0, '0);
    end
    @(negedge clk) start <= 1'b0;

    while (quat_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fails == 0) begin
      $display("rotation_matrix_to_quaternion_tb OK");
    end else begin
      $display("rotation_matrix_to_quaternion_tb NOT OK");
    end
    $finish;
  end

endmodule
